[rtl/roct_pkg.sv]
// shared types and constants for the outstanding call tracker
// depends on nothing; used by roct_ctrl, roct_dp and rpc_outstanding_call_tracker
package roct_pkg;

	localparam int TIMEOUT_W = 22;

	localparam logic [1:0] OP_SEND = 2'd0;
	localparam logic [1:0] OP_RESP = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET       = 22'd10000;
	localparam logic [31:0]          ERROR_METHOD        = 32'hFFFF_FFFF;
	localparam logic [31:0]          SUCCESS_METHOD_MASK = 32'h0000_7FFF;
	localparam logic [4:0]           RESULT_LIMIT        = 5'd16;

	typedef enum logic [2:0] {
		KIND_SENT       = 3'd0,
		KIND_NO_LINK    = 3'd1,
		KIND_FULL       = 3'd2,
		KIND_DELIVER    = 3'd3,
		KIND_SUPPRESSED = 3'd4,
		KIND_UNMATCHED  = 3'd5,
		KIND_TIMED_OUT  = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] call;
		logic [6:0]  proto;
		logic [31:0] method;
	} result_t;

	typedef struct packed {
		logic [31:0] call;
		logic [6:0]  proto;
		logic [31:0] method;
		logic        wants_errors;
		logic [31:0] start_time;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic send;
		logic scan_init;
		logic rd_issue;
		logic ev_step;
		logic scan_end;
		logic flush;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic ev_ok;
		logic pend_valid;
		logic out_free;
	} dp_status_t;

endpackage

[rtl/roct_ctrl.sv]
// sequencing controller of the outstanding call tracker
// depends on roct_pkg; drives the command struct of roct_dp
module roct_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           opcode,
	input  roct_pkg::dp_status_t st,
	output roct_pkg::dp_cmd_t    cmd
);
	import roct_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SEND  = 5'b00010,
		S_RD    = 5'b00100,
		S_EV    = 5'b01000,
		S_FLUSH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (opcode == OP_SEND) begin
						state_d = S_SEND;
					end else if (opcode == OP_RESP || opcode == OP_TICK) begin
						cmd.scan_init = 1'b1;
						state_d = S_RD;
					end
				end
			end
			S_SEND: begin
				cmd.send = 1'b1;
				state_d = S_FLUSH;
			end
			S_RD: begin
				if (st.scan_done) begin
					cmd.scan_end = 1'b1;
					state_d = S_FLUSH;
				end else begin
					cmd.rd_issue = 1'b1;
					state_d = S_EV;
				end
			end
			S_EV: begin
				// a removal with a result already pending needs the output register free
				if (st.ev_ok) begin
					cmd.ev_step = 1'b1;
					state_d = S_RD;
				end
			end
			S_FLUSH: begin
				if (!st.pend_valid) begin
					state_d = S_IDLE;
				end else if (st.out_free) begin
					cmd.flush = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/roct_dp.sv]
// datapath of the outstanding call tracker: call table memory, scan pointers,
// pending result and output register; depends on roct_pkg, driven by roct_ctrl
module roct_dp #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  roct_pkg::dp_cmd_t                cmd,
	output roct_pkg::dp_status_t             st,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [roct_pkg::TIMEOUT_W-1:0]   cfg_data,
	input  logic [1:0]                       opcode,
	input  logic                             link_up,
	input  logic [6:0]                       protocol_id,
	input  logic [31:0]                      method_id,
	input  logic [31:0]                      call_id,
	input  logic                             is_success,
	input  logic                             handle_error,
	input  logic [31:0]                      now_ms,
	output logic                             out_valid,
	input  logic                             out_stall,
	output roct_pkg::result_t                out_res,
	output logic                             out_last
);
	import roct_pkg::*;

	localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

	entry_t mem [TABLE_DEPTH];
	entry_t rd_data_q;

	logic [TIMEOUT_W-1:0] timeout_q;
	logic [31:0]          next_call_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     rptr_q;
	logic [CNT_W-1:0]     wptr_q;
	logic                 found_q;
	logic [4:0]           nexp_q;

	logic [1:0]  it_op_q;
	logic        it_link_q;
	logic [6:0]  it_proto_q;
	logic [31:0] it_method_q;
	logic [31:0] it_call_q;
	logic        it_success_q;
	logic        it_herr_q;
	logic [31:0] it_now_q;

	result_t pend_q;
	logic    pend_v_q;
	result_t out_res_q;
	logic    out_v_q;
	logic    out_last_q;

	logic        match;
	logic        expire;
	logic        remove;
	logic [31:0] age;
	logic [31:0] resp_method;
	logic        out_free;
	logic        push_mid;
	logic        send_ok;
	result_t     ev_res;
	result_t     send_res;
	result_t     miss_res;
	entry_t      new_entry;
	logic        mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	entry_t      mem_wdata;

	assign resp_method = it_success_q ? (it_method_q & SUCCESS_METHOD_MASK) : ERROR_METHOD;
	assign age = it_now_q - rd_data_q.start_time;

	assign match = (it_op_q == OP_RESP) && !found_q
		&& (rd_data_q.call == it_call_q) && (rd_data_q.proto == it_proto_q)
		&& (!it_success_q || rd_data_q.method == resp_method);
	assign expire = (it_op_q == OP_TICK) && (nexp_q < RESULT_LIMIT)
		&& (age >= {{(32 - TIMEOUT_W){1'b0}}, timeout_q});
	assign remove = match || expire;

	assign out_free = !out_v_q || !out_stall;
	assign push_mid = cmd.ev_step && remove && pend_v_q;
	assign send_ok = it_link_q && (count_q != DEPTH_CNT);

	assign st.scan_done  = (rptr_q == count_q);
	assign st.ev_ok      = !(remove && pend_v_q) || out_free;
	assign st.pend_valid = pend_v_q;
	assign st.out_free   = out_free;

	always_comb begin
		ev_res.kind   = match ? ((it_success_q || rd_data_q.wants_errors) ? KIND_DELIVER
			: KIND_SUPPRESSED) : KIND_TIMED_OUT;
		ev_res.call   = rd_data_q.call;
		ev_res.proto  = rd_data_q.proto;
		ev_res.method = rd_data_q.method;

		send_res.kind   = !it_link_q ? KIND_NO_LINK : (send_ok ? KIND_SENT : KIND_FULL);
		send_res.call   = next_call_q;
		send_res.proto  = it_proto_q;
		send_res.method = it_method_q;

		miss_res.kind   = KIND_UNMATCHED;
		miss_res.call   = it_call_q;
		miss_res.proto  = it_proto_q;
		miss_res.method = resp_method;

		new_entry.call         = next_call_q;
		new_entry.proto        = it_proto_q;
		new_entry.method       = it_method_q;
		new_entry.wants_errors = it_herr_q;
		new_entry.start_time   = it_now_q;

		// compaction writes kept entries down to the write pointer
		mem_we    = 1'b0;
		mem_waddr = wptr_q[ADDR_W-1:0];
		mem_wdata = rd_data_q;
		if (cmd.send && send_ok) begin
			mem_we    = 1'b1;
			mem_waddr = count_q[ADDR_W-1:0];
			mem_wdata = new_entry;
		end else if (cmd.ev_step && !remove) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= mem[rptr_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			it_op_q      <= opcode;
			it_link_q    <= link_up;
			it_proto_q   <= protocol_id;
			it_method_q  <= method_id;
			it_call_q    <= call_id;
			it_success_q <= is_success;
			it_herr_q    <= handle_error;
			it_now_q     <= now_ms;
		end
		if (cmd.send) begin
			pend_q <= send_res;
		end else if (cmd.ev_step && remove) begin
			pend_q <= ev_res;
		end else if (cmd.scan_end && it_op_q == OP_RESP && !found_q) begin
			pend_q <= miss_res;
		end
		if (push_mid || cmd.flush) begin
			out_res_q  <= pend_q;
			out_last_q <= cmd.flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RESET;
			next_call_q <= 32'd1;
			count_q     <= '0;
			rptr_q      <= '0;
			wptr_q      <= '0;
			found_q     <= 1'b0;
			nexp_q      <= '0;
			pend_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
			if (cmd.send) begin
				next_call_q <= next_call_q + 32'd1;
				if (send_ok) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.scan_init) begin
				rptr_q  <= '0;
				wptr_q  <= '0;
				found_q <= 1'b0;
				nexp_q  <= '0;
			end
			if (cmd.ev_step) begin
				rptr_q <= rptr_q + CNT_W'(1);
				if (remove) begin
					found_q <= found_q || match;
					nexp_q  <= nexp_q + {4'd0, expire};
				end else begin
					wptr_q <= wptr_q + CNT_W'(1);
				end
			end
			if (cmd.scan_end) begin
				count_q <= wptr_q;
			end
			if (cmd.send || (cmd.ev_step && remove)
				|| (cmd.scan_end && it_op_q == OP_RESP && !found_q)) begin
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
			if (push_mid || cmd.flush) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_res   = out_res_q;
	assign out_last  = out_last_q;

`ifndef ASSERT_OFF
	a_wptr_behind: assert property (@(posedge clk) disable iff (!arst_n)
		wptr_q <= rptr_q)
		else $error("write pointer ran ahead of read pointer");

	a_expiry_limit: assert property (@(posedge clk) disable iff (!arst_n)
		nexp_q <= RESULT_LIMIT)
		else $error("too many expiries in one tick");

	a_call_number_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.send |=> next_call_q == $past(next_call_q) + 32'd1)
		else $error("call number not consumed by send");

	a_count_on_send: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.send && send_ok |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("accepted send did not grow the table");

	a_flush_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> pend_v_q && out_free)
		else $error("flush without pending result or output room");
`endif

endmodule

[rtl/rpc_outstanding_call_tracker.sv]
// Tracks outstanding remote calls in an ordered table and reports send, match and
// timeout results. Top level: roct_ctrl sequencer plus roct_dp datapath; needs roct_pkg.
//
// Input channel (in_valid/in_stall): one transaction per opcode. A send takes the
// next call number and gives one result. A response scans the table oldest first,
// removes the first matching entry and gives one result (deliver, suppressed or
// unmatched). A tick scans in insertion order and gives one result per expired
// entry, at most 16, possibly none. is_last marks the final result of a transaction.
// For each entry, the scan of a response or tick reads the table memory, then
// compares and compacts. The block takes the next input while the last result
// still sits in the output register.
// Output channel (out_valid/out_stall): a stall holds the result and pauses the scan
// when a second result is ready. Config channel (cfg_valid/cfg_ready, always ready)
// writes timeout_ms; write only while the block is idle.
// Reset: table empty, next call number 1, timeout 10000 ms; no clearing pass.
module rpc_outstanding_call_tracker #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic        link_up,
	input  logic [6:0]  protocol_id,
	input  logic [31:0] method_id,
	input  logic [31:0] call_id,
	input  logic        is_success,
	input  logic        handle_error,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_kind,
	output logic [31:0] tag_call_id,
	output logic [6:0]  tag_protocol,
	output logic [31:0] tag_method,
	output logic        is_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [21:0] cfg_data
);
	import roct_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;
	result_t    out_res;

	assign cfg_ready = 1'b1;

	roct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.st       (st),
		.cmd      (cmd)
	);

	roct_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.opcode       (opcode),
		.link_up      (link_up),
		.protocol_id  (protocol_id),
		.method_id    (method_id),
		.call_id      (call_id),
		.is_success   (is_success),
		.handle_error (handle_error),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_res      (out_res),
		.out_last     (is_last)
	);

	assign result_kind  = out_res.kind;
	assign tag_call_id  = out_res.call;
	assign tag_protocol = out_res.proto;
	assign tag_method   = out_res.method;

endmodule
